// ===== rtl/csfc_pkg.sv =====
// shared types and constants of the response frame checker
package csfc_pkg;

    // frame layout
    localparam logic [7:0] HEADER_BYTE  = 8'h3E;
    localparam logic [8:0] HEADER_BYTES = 9'd5;
    localparam logic [8:0] POS_MAX      = 9'd261;

    // result queue geometry
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // status reason codes
    typedef enum logic [2:0] {
        FAIL_NONE   = 3'd0,
        FAIL_SHORT  = 3'd1,
        FAIL_HEADER = 3'd2,
        FAIL_CMD    = 3'd3,
        FAIL_ID     = 3'd4,
        FAIL_HSUM   = 3'd5,
        FAIL_TRUNC  = 3'd6,
        FAIL_DSUM   = 3'd7
    } fail_t;

    // one result item
    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_status;
        logic       frame_ok;
        logic [2:0] fail_reason;
    } out_item_t;

endpackage

// ===== rtl/csfc_in_if.sv =====
// receive byte channel
interface csfc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       rx_last;
    logic [7:0] expected_cmd;

    modport source (output valid, output rx_byte, output rx_last, output expected_cmd,
                    input ready);
    modport sink   (input valid, input rx_byte, input rx_last, input expected_cmd,
                    output ready);
endinterface

// ===== rtl/csfc_out_if.sv =====
// result item channel
interface csfc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       is_status;
    logic       frame_ok;
    logic [2:0] fail_reason;

    modport source (output valid, output out_byte, output is_status, output frame_ok,
                    output fail_reason, input ready);
    modport sink   (input valid, input out_byte, input is_status, input frame_ok,
                    input fail_reason, output ready);
endinterface

// ===== rtl/csfc_cfg_if.sv =====
// configuration write channel
interface csfc_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/checksummed_response_frame_checker.sv =====
// response frame checker: byte parser, checksum checks and result queue
//
//   channel  dir  moves                         payload
//   rx       in   one response byte             rx_byte, rx_last, expected_cmd
//   result   out  payload byte or status        out_byte, is_status, frame_ok, fail_reason
//   cfg      in   device id write               data
//
// one byte is taken per cycle while rx.ready is high; its checks and running sums are
// settled in the accepting cycle and its results (up to two) go into a four-entry result queue.
// rx.ready is high while the queue has room for two results, so a stalled
// result side stops input once fewer than two entries are free.
// rst_n clears the frame state and the queue and sets the device id to 1.
// cfg writes are always taken.
module checksummed_response_frame_checker (
    input  logic         clk,
    input  logic         rst_n,
    csfc_in_if.sink      rx,
    csfc_out_if.source   result,
    csfc_cfg_if.sink     cfg
);
    import csfc_pkg::*;

    logic [7:0]  dev_id_reg;
    logic [8:0]  pos_reg, pos_next;
    logic [7:0]  len_reg, len_next;
    logic [7:0]  hsum_reg, hsum_next;
    logic [7:0]  psum_reg, psum_next;
    fail_t       ff_reg, ff_next;

    fail_t       fail_code;
    fail_t       reason;
    logic        emit;
    logic [8:0]  data_end;
    logic        rx_fire;
    logic        tx_fire;

    out_item_t                  queue_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]        wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_AW:0]          count_reg;
    logic [1:0]                 n_push;
    out_item_t                  item_a, item_b;
    out_item_t                  pay_item, stat_item;

    assign cfg.ready = 1'b1;
    assign rx_fire   = rx.valid && rx.ready;
    assign tx_fire   = result.valid && result.ready;
    assign data_end  = HEADER_BYTES + {1'b0, len_reg};

    // per-byte checks and state update
    always_comb
    begin
        fail_code = FAIL_NONE;
        emit      = 1'b0;
        len_next  = len_reg;
        hsum_next = hsum_reg;
        psum_next = psum_reg;
        if (pos_reg < 9'd4)
        begin
            hsum_next = hsum_reg + rx.rx_byte;
            if (pos_reg == 9'd0 && rx.rx_byte != HEADER_BYTE)
                fail_code = FAIL_HEADER;
            else if (pos_reg == 9'd1 && rx.rx_byte != rx.expected_cmd)
                fail_code = FAIL_CMD;
            else if (pos_reg == 9'd2 && rx.rx_byte != dev_id_reg)
                fail_code = FAIL_ID;
            else if (pos_reg == 9'd3)
                len_next = rx.rx_byte;
        end
        else if (pos_reg == 9'd4)
        begin
            if (hsum_reg != rx.rx_byte)
                fail_code = FAIL_HSUM;
        end
        else if (len_reg != 8'd0)
        begin
            if (pos_reg < data_end)
            begin
                psum_next = psum_reg + rx.rx_byte;
                emit      = (ff_reg == FAIL_NONE);
            end
            else if (pos_reg == data_end)
            begin
                if (psum_reg != rx.rx_byte)
                    fail_code = FAIL_DSUM;
            end
        end

        ff_next  = (ff_reg != FAIL_NONE) ? ff_reg : fail_code;
        pos_next = (pos_reg < POS_MAX) ? pos_reg + 9'd1 : pos_reg;

        // status reason in check order
        priority if (pos_reg < 9'd4)
            reason = FAIL_SHORT;
        else if (ff_next != FAIL_NONE)
            reason = ff_next;
        else if (len_reg != 8'd0 && pos_reg < data_end)
            reason = FAIL_TRUNC;
        else
            reason = FAIL_NONE;

        // end of response clears the frame
        if (rx.rx_last)
        begin
            pos_next  = 9'd0;
            len_next  = 8'd0;
            hsum_next = 8'd0;
            psum_next = 8'd0;
            ff_next   = FAIL_NONE;
        end
    end

    // result items for this transaction
    always_comb
    begin
        pay_item.out_byte     = rx.rx_byte;
        pay_item.is_status    = 1'b0;
        pay_item.frame_ok     = 1'b0;
        pay_item.fail_reason  = 3'd0;
        stat_item.out_byte    = 8'd0;
        stat_item.is_status   = 1'b1;
        stat_item.frame_ok    = (reason == FAIL_NONE);
        stat_item.fail_reason = 3'(reason);
        item_a = emit ? pay_item : stat_item;
        item_b = stat_item;
        n_push = 2'(emit) + 2'(rx.rx_last);
        if (!rx_fire)
            n_push = 2'd0;
    end

    // frame state and device id
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_id_reg <= 8'd1;
            pos_reg    <= 9'd0;
            len_reg    <= 8'd0;
            hsum_reg   <= 8'd0;
            psum_reg   <= 8'd0;
            ff_reg     <= FAIL_NONE;
        end
        else
        begin
            if (cfg.valid)
                dev_id_reg <= cfg.data;
            if (rx_fire)
            begin
                pos_reg  <= pos_next;
                len_reg  <= len_next;
                hsum_reg <= hsum_next;
                psum_reg <= psum_next;
                ff_reg   <= ff_next;
            end
        end
    end

    // result queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + QUEUE_AW'(n_push);
            if (tx_fire)
                rd_ptr_reg <= rd_ptr_reg + QUEUE_AW'(1);
            count_reg <= count_reg + (QUEUE_AW+1)'(n_push) - (QUEUE_AW+1)'(tx_fire);
        end
    end

    // result queue storage
    always_ff @(posedge clk)
    begin
        if (n_push != 2'd0)
            queue_reg[wr_ptr_reg] <= item_a;
        if (n_push == 2'd2)
            queue_reg[wr_ptr_reg + QUEUE_AW'(1)] <= item_b;
    end

    assign rx.ready           = (count_reg <= (QUEUE_AW+1)'(QUEUE_DEPTH - 2));
    assign result.valid       = (count_reg != '0);
    assign result.out_byte    = queue_reg[rd_ptr_reg].out_byte;
    assign result.is_status   = queue_reg[rd_ptr_reg].is_status;
    assign result.frame_ok    = queue_reg[rd_ptr_reg].frame_ok;
    assign result.fail_reason = queue_reg[rd_ptr_reg].fail_reason;

    // queue never overfills
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (QUEUE_AW+1)'(QUEUE_DEPTH))
        else $error("result queue overflow");

    // position stays within its saturation limit
    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_MAX)
        else $error("byte position out of range");

    // last byte restarts the frame
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        rx_fire && rx.rx_last |=> pos_reg == 9'd0 && ff_reg == FAIL_NONE)
        else $error("frame state not cleared after last byte");

    // a payload item is pushed only while no failure is held
    a_emit_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rx_fire && emit |-> ff_reg == FAIL_NONE && len_reg != 8'd0)
        else $error("payload passed out after failure");

endmodule

// ===== dv/tb_checksummed_response_frame_checker.sv =====
// testbench for the response frame checker: directed and random responses against a predictor
module tb_checksummed_response_frame_checker;
    import csfc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CLK_PERIOD    = 10;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned IDLE_LIMIT    = 4000;
    localparam int unsigned HOLD_CYCLES   = 300;

    // ways a well-formed response gets broken
    typedef enum int unsigned {
        BREAK_HEADER,
        BREAK_CMD,
        BREAK_ID,
        BREAK_HSUM,
        BREAK_TRUNC,
        BREAK_DSUM,
        BREAK_SHORT
    } break_t;

    logic clk = 1'b0;
    logic rst_n;

    csfc_in_if  rx_ch ();
    csfc_out_if res_ch ();
    csfc_cfg_if cfg_ch ();

    checksummed_response_frame_checker dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .rx     (rx_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    // predictor state, mirrors the frame parser
    logic [7:0]  dev_id      = 8'd1;
    int unsigned frame_pos   = 0;
    logic [7:0]  frame_len   = 8'd0;
    logic [7:0]  run_hsum    = 8'd0;
    logic [7:0]  run_psum    = 8'd0;
    fail_t       frame_fail  = FAIL_NONE;

    out_item_t   predicted_results[$];
    logic [7:0]  frame_buf[$];
    int unsigned mismatch_count = 0;
    int unsigned idle_cycles    = 0;

    // idling controls
    bit          tx_gaps_on     = 1'b1;
    bit          sink_stalls_on = 1'b1;
    int unsigned hold_cycles    = 0;
    int unsigned stall_left     = 0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    // mostly short gaps, a few long ones
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    function automatic void note_failure(fail_t code);
        if (frame_fail == FAIL_NONE)
            frame_fail = code;
    endfunction

    // advance the parser by one accepted byte and queue what it emits
    function automatic void parse_rx_byte(logic [7:0] b, logic last, logic [7:0] cmd);
        int unsigned at;
        int unsigned count;
        out_item_t   item;
        fail_t       why;
        at = frame_pos;
        if (at < 4) begin
            run_hsum = run_hsum + b;
            if (at == 0 && b != HEADER_BYTE)
                note_failure(FAIL_HEADER);
            else if (at == 1 && b != cmd)
                note_failure(FAIL_CMD);
            else if (at == 2 && b != dev_id)
                note_failure(FAIL_ID);
            else if (at == 3)
                frame_len = b;
        end
        else if (at == 4) begin
            if (run_hsum != b)
                note_failure(FAIL_HSUM);
        end
        else if (frame_len != 8'd0) begin
            if (at < HEADER_BYTES + frame_len) begin
                run_psum = run_psum + b;
                if (frame_fail == FAIL_NONE) begin
                    item = '{out_byte: b, is_status: 1'b0, frame_ok: 1'b0,
                             fail_reason: FAIL_NONE};
                    predicted_results = {predicted_results, item};
                end
            end
            else if (at == HEADER_BYTES + frame_len) begin
                if (run_psum != b)
                    note_failure(FAIL_DSUM);
            end
        end
        if (frame_pos < POS_MAX)
            frame_pos++;

        // status on the byte marked last, then back to idle
        if (last) begin
            count = at + 1;
            if (count < HEADER_BYTES)
                why = FAIL_SHORT;
            else if (frame_fail != FAIL_NONE)
                why = frame_fail;
            else if (frame_len != 8'd0 && count < HEADER_BYTES + frame_len + 1)
                why = FAIL_TRUNC;
            else
                why = FAIL_NONE;
            item = '{out_byte: 8'd0, is_status: 1'b1, frame_ok: (why == FAIL_NONE),
                     fail_reason: why};
            predicted_results = {predicted_results, item};
            frame_pos  = 0;
            frame_len  = 8'd0;
            run_hsum   = 8'd0;
            run_psum   = 8'd0;
            frame_fail = FAIL_NONE;
        end
    endfunction

    function automatic void check_result(logic [7:0] out_byte, logic is_status,
                                         logic frame_ok, logic [2:0] fail_reason);
        out_item_t want;
        if (predicted_results.size() == 0) begin
            $error("unexpected result: out_byte %0h is_status %0b frame_ok %0b fail_reason %0d",
                   out_byte, is_status, frame_ok, fail_reason);
            mismatch_count++;
            return;
        end
        want = predicted_results.pop_front();
        if (out_byte !== want.out_byte) begin
            $error("out_byte: expected %0h, got %0h", want.out_byte, out_byte);
            mismatch_count++;
        end
        if (is_status !== want.is_status) begin
            $error("is_status: expected %0b, got %0b", want.is_status, is_status);
            mismatch_count++;
        end
        if (frame_ok !== want.frame_ok) begin
            $error("frame_ok: expected %0b, got %0b", want.frame_ok, frame_ok);
            mismatch_count++;
        end
        if (fail_reason !== want.fail_reason) begin
            $error("fail_reason: expected %0d, got %0d", want.fail_reason, fail_reason);
            mismatch_count++;
        end
    endfunction

    // predict on accepted input, check each accepted result
    always @(posedge clk) begin
        if (cfg_ch.valid && cfg_ch.ready)
            dev_id = cfg_ch.data;
        if (rx_ch.valid && rx_ch.ready)
            parse_rx_byte(rx_ch.rx_byte, rx_ch.rx_last, rx_ch.expected_cmd);
        if (res_ch.valid && res_ch.ready)
            check_result(res_ch.out_byte, res_ch.is_status, res_ch.frame_ok,
                         res_ch.fail_reason);
    end

    // watchdog on cycles with no transaction on any channel
    always @(posedge clk) begin
        if ((rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_checksummed_response_frame_checker: errors");
            $finish;
        end
    end

    // result side ready: long hold-off, random stalls or always ready
    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_cycles != 0) begin
                res_ch.ready <= 1'b0;
                hold_cycles--;
            end
            else if (stall_left != 0) begin
                res_ch.ready <= 1'b0;
                stall_left--;
            end
            else if (sink_stalls_on && $urandom_range(0, 99) < 30) begin
                stall_left = pick_gap();
                res_ch.ready <= (stall_left == 0);
            end
            else
                res_ch.ready <= 1'b1;
        end
    end

    // one byte transaction, with an optional gap before it
    task automatic send_byte(input logic [7:0] b, input logic last, input logic [7:0] cmd);
        int unsigned gap;
        gap = tx_gaps_on ? pick_gap() : 0;
        @(negedge clk);
        if (gap != 0) begin
            rx_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        rx_ch.valid        <= 1'b1;
        rx_ch.rx_byte      <= b;
        rx_ch.rx_last      <= last;
        rx_ch.expected_cmd <= cmd;
        do @(posedge clk); while (!rx_ch.ready);
    endtask

    // send the buffered response; expected_cmd only matters on the second byte
    task automatic send_buf(input logic [7:0] cmd);
        for (int i = 0; i < frame_buf.size(); i++)
            send_byte(frame_buf[i], i == frame_buf.size() - 1,
                      (i == 1) ? cmd : 8'($urandom_range(0, 255)));
    endtask

    // well-formed response: header, sums, payload random or alternating 00/ff
    task automatic build_frame(input logic [7:0] cmd, input logic [7:0] id,
                               input int unsigned len, input bit extremes);
        logic [7:0] dsum;
        logic [7:0] b;
        logic [7:0] hsum;
        hsum = HEADER_BYTE + cmd + id + 8'(len);
        frame_buf = {HEADER_BYTE, cmd, id, 8'(len), hsum};
        dsum = 8'd0;
        for (int i = 0; i < len; i++) begin
            b = extremes ? ((i % 2) ? 8'hFF : 8'h00) : 8'($urandom_range(0, 255));
            dsum = dsum + b;
            frame_buf = {frame_buf, b};
        end
        if (len != 0)
            frame_buf = {frame_buf, dsum};
    endtask

    // sender pauses until every result is in and the parser has settled
    task automatic wait_results_drained();
        @(negedge clk);
        rx_ch.valid <= 1'b0;
        while (predicted_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_device_id(input logic [7:0] id);
        wait_results_drained();
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= id;
        do @(posedge clk); while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // one response per check, plus ordering and saturation cases
    task automatic test_directed_frames();
        // minimal good frame, then payload extremes with command 00 and ff
        build_frame(8'h5A, dev_id, 0, 1'b0);
        send_buf(8'h5A);
        build_frame(8'h00, dev_id, 2, 1'b1);
        send_buf(8'h00);
        build_frame(8'hFF, dev_id, 1, 1'b1);
        send_buf(8'hFF);
        // too short: one byte, four bytes, and short wins over a bad header
        build_frame(8'h5A, dev_id, 3, 1'b0);
        frame_buf = frame_buf[0:0];
        send_buf(8'h5A);
        build_frame(8'h5A, dev_id, 3, 1'b0);
        frame_buf = frame_buf[0:3];
        send_buf(8'h5A);
        build_frame(8'h5A, dev_id, 3, 1'b0);
        frame_buf[0] = 8'h00;
        frame_buf = frame_buf[0:1];
        send_buf(8'hA5);
        // bad header byte with wrong command: header reported
        build_frame(8'h5A, dev_id, 2, 1'b0);
        frame_buf[0] = 8'h3F;
        send_buf(8'hA5);
        // wrong command, wrong id with payload held back
        build_frame(8'h5A, dev_id, 2, 1'b0);
        send_buf(8'hA5);
        build_frame(8'h5A, dev_id ^ 8'h01, 2, 1'b0);
        send_buf(8'h5A);
        // header sum
        build_frame(8'h5A, dev_id, 2, 1'b0);
        frame_buf[4] = frame_buf[4] ^ 8'h01;
        send_buf(8'h5A);
        // truncated payload, and last payload byte marked last
        build_frame(8'h5A, dev_id, 4, 1'b0);
        frame_buf = frame_buf[0:6];
        send_buf(8'h5A);
        build_frame(8'h5A, dev_id, 3, 1'b0);
        frame_buf = frame_buf[0:7];
        send_buf(8'h5A);
        // wrong id on a truncated frame: id reported
        build_frame(8'h5A, dev_id ^ 8'h80, 3, 1'b0);
        frame_buf = frame_buf[0:6];
        send_buf(8'h5A);
        // data sum
        build_frame(8'h5A, dev_id, 3, 1'b0);
        frame_buf[8] = frame_buf[8] ^ 8'h80;
        send_buf(8'h5A);
        // longest payload with trailing bytes past the position limit
        build_frame(8'hC3, dev_id, 255, 1'b1);
        repeat (5) frame_buf = {frame_buf, 8'($urandom_range(0, 255))};
        send_buf(8'hC3);
    endtask

    // device id extremes and random values, each with a matching and a wrong id
    task automatic test_device_id();
        logic [7:0] ids[5];
        logic [7:0] cmd;
        ids = '{8'h00, 8'hFF, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 8'h01};
        foreach (ids[k]) begin
            write_device_id(ids[k]);
            repeat (2) begin
                cmd = 8'($urandom_range(0, 255));
                build_frame(cmd, ids[k], $urandom_range(0, 4), 1'b0);
                send_buf(cmd);
            end
            cmd = 8'($urandom_range(0, 255));
            build_frame(cmd, ids[k] ^ 8'($urandom_range(1, 255)), 2, 1'b0);
            send_buf(cmd);
        end
    endtask

    // result side held off while bytes keep coming, so the queue backs up and stops input
    task automatic test_result_backpressure();
        logic [7:0] cmd;
        tx_gaps_on     = 1'b0;
        sink_stalls_on = 1'b0;
        @(negedge clk);
        rx_ch.valid <= 1'b0;
        hold_cycles = HOLD_CYCLES;
        repeat (6) begin
            cmd = 8'($urandom_range(0, 255));
            build_frame(cmd, dev_id, $urandom_range(8, 20), 1'b0);
            send_buf(cmd);
        end
        wait_results_drained();
        tx_gaps_on     = 1'b1;
        sink_stalls_on = 1'b1;
    endtask

    // mostly well-formed responses, some broken ones, trailing bytes and noise
    task automatic test_random_responses(input int unsigned n_bytes);
        int unsigned sent;
        int unsigned pick;
        int unsigned len;
        int unsigned r;
        logic [7:0]  cmd;
        logic [7:0]  cmd_back;
        break_t      kind;
        sent = 0;
        while (sent < n_bytes) begin
            cmd      = 8'($urandom_range(0, 255));
            cmd_back = cmd;
            pick     = $urandom_range(0, 99);
            r        = $urandom_range(0, 99);
            if (r < 70)
                len = $urandom_range(0, 6);
            else if (r < 98)
                len = $urandom_range(7, 40);
            else
                len = $urandom_range(41, 255);
            if (pick < 90) begin
                build_frame(cmd, dev_id, len, 1'b0);
                if (pick >= 60 && pick < 85) begin
                    kind = break_t'($urandom_range(0, 6));
                    if ((kind == BREAK_TRUNC || kind == BREAK_DSUM) && len == 0)
                        kind = BREAK_SHORT;
                    case (kind)
                        BREAK_HEADER: frame_buf[0] = frame_buf[0] ^ 8'($urandom_range(1, 255));
                        BREAK_CMD:    cmd_back = cmd ^ 8'($urandom_range(1, 255));
                        BREAK_ID:     frame_buf[2] = frame_buf[2] ^ 8'($urandom_range(1, 255));
                        BREAK_HSUM:   frame_buf[4] = frame_buf[4] ^ 8'($urandom_range(1, 255));
                        BREAK_TRUNC:  repeat ($urandom_range(1, len + 1))
                                          void'(frame_buf.pop_back());
                        BREAK_DSUM:   frame_buf[frame_buf.size() - 1] =
                                          frame_buf[frame_buf.size() - 1] ^
                                          8'($urandom_range(1, 255));
                        default:      frame_buf = frame_buf[0:$urandom_range(0, 3)];
                    endcase
                end
                else if (pick >= 85) begin
                    repeat ($urandom_range(1, 12))
                        frame_buf = {frame_buf, 8'($urandom_range(0, 255))};
                end
            end
            else begin
                frame_buf = {};
                repeat ($urandom_range(1, 12))
                    frame_buf = {frame_buf, 8'($urandom_range(0, 255))};
            end
            send_buf(cmd_back);
            sent += frame_buf.size();
        end
    endtask

    initial begin
        rst_n              = 1'b0;
        rx_ch.valid        = 1'b0;
        rx_ch.rx_byte      = 8'd0;
        rx_ch.rx_last      = 1'b0;
        rx_ch.expected_cmd = 8'd0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.data        = 8'd0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_frames();
        test_device_id();
        test_result_backpressure();
        test_random_responses(1000);
        write_device_id(8'($urandom_range(0, 255)));
        // stretch with no idling on either side
        tx_gaps_on     = 1'b0;
        sink_stalls_on = 1'b0;
        test_random_responses(500);

        wait_results_drained();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && predicted_results.size() == 0)
            $display("tb_checksummed_response_frame_checker: clean");
        else
            $display("tb_checksummed_response_frame_checker: errors");
        $finish;
    end

endmodule
